[hdl/box_area_downscaler_rgb_defines.svh]
// Assertion helpers for the box_area_downscaler_rgb RTL file.
`ifndef BOX_AREA_DOWNSCALER_RGB_DEFINES_SVH
`define BOX_AREA_DOWNSCALER_RGB_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define BADS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define BADS_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

[hdl/bads_pkg.sv]
package bads_pkg;

    localparam int CH_W     = 8;
    localparam int OCOL_W   = 10;
    localparam int OROW_W   = 12;
    localparam int SUM_W    = 32;
    localparam int DIV_NW   = SUM_W + 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_W = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_H = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_W = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_H = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_READ,
        S_ACC,
        S_EMIT
    } t_state;

    typedef enum logic [2:0] {
        OP_CS,
        OP_CE,
        OP_RS,
        OP_RE,
        OP_MR,
        OP_MG,
        OP_MB
    } t_op;

endpackage

[hdl/bads_in_if.sv]
interface bads_in_if;
    import bads_pkg::*;
    logic              valid;
    logic              ready;
    logic [CH_W-1:0]   pixel_red;
    logic [CH_W-1:0]   pixel_green;
    logic [CH_W-1:0]   pixel_blue;
    logic              frame_start;

    modport source (output valid, pixel_red, pixel_green, pixel_blue, frame_start,
                    input ready);
    modport sink   (input valid, pixel_red, pixel_green, pixel_blue, frame_start,
                    output ready);
endinterface

[hdl/bads_out_if.sv]
interface bads_out_if;
    import bads_pkg::*;
    logic              valid;
    logic              ready;
    logic [CH_W-1:0]   avg_red;
    logic [CH_W-1:0]   avg_green;
    logic [CH_W-1:0]   avg_blue;
    logic [OCOL_W-1:0] out_column;
    logic [OROW_W-1:0] out_row;
    logic              frame_end;

    modport source (output valid, avg_red, avg_green, avg_blue, out_column, out_row,
                    frame_end, input ready);
    modport sink   (input valid, avg_red, avg_green, avg_blue, out_column, out_row,
                    frame_end, output ready);
endinterface

[hdl/bads_div.sv]
module bads_div #(
    parameter int N_W = 34,
    parameter int D_W = 26
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_num,
    input  logic [D_W-1:0] i_den,
    output logic           o_busy,
    output logic           o_done,
    output logic [N_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(N_W + 1);

    logic [D_W-1:0]   r_rem, n_rem;
    logic [D_W-1:0]   r_den;
    logic [N_W-1:0]   r_quo, n_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy, r_done;
    logic [D_W:0]     w_trial;

    // one quotient bit per cycle, restoring
    always_comb begin
        w_trial = {r_rem, r_quo[N_W-1]};
        if (w_trial >= {1'b0, r_den}) begin
            n_rem = D_W'(w_trial - {1'b0, r_den});
            n_quo = {r_quo[N_W-2:0], 1'b1};
        end else begin
            n_rem = w_trial[D_W-1:0];
            n_quo = {r_quo[N_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(N_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem <= '0;
            r_den <= i_den;
            r_quo <= i_num;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quo;
endmodule

[hdl/box_area_downscaler_rgb.sv]
// channel  dir  handshake        payload
// i_pix    in   valid/ready      pixel_red, pixel_green, pixel_blue, frame_start
// o_avg    out  valid/ready      avg_red, avg_green, avg_blue, out_column, out_row, frame_end
// i_cfg_*  in   write enable     register index, write data
// Each pixel runs four divisions, and three more when it closes a region: one
// shared radix-2 divider works out the four region boundaries and the three means.
// The line store is one read-modify-write per pixel through a single-port RAM.
// No clearing pass after reset; the control state clears on the synchronous reset.
// A result waits in the output register while the next pixel is taken in.
`include "box_area_downscaler_rgb_defines.svh"

module box_area_downscaler_rgb #(
    parameter int MAX_SRC_WIDTH  = 4096,
    parameter int MAX_SRC_HEIGHT = 4096,
    parameter int MAX_DST_WIDTH  = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [bads_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bads_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    bads_in_if.sink                    i_pix,
    bads_out_if.source                 o_avg
);
    import bads_pkg::*;

    localparam int SWW = $clog2(MAX_SRC_WIDTH + 1);
    localparam int SHW = $clog2(MAX_SRC_HEIGHT + 1);
    localparam int DCW = $clog2(MAX_DST_WIDTH + 1);
    localparam int AW  = $clog2(MAX_DST_WIDTH);
    localparam int NW  = SWW + SHW;
    localparam int DVW = NW + 1;
    localparam int MW  = 3 * SUM_W;

    logic [12:0] r_src_w, r_src_h, r_dst_h;
    logic [10:0] r_dst_w;

    t_state r_state, n_state;
    t_op    r_op;
    logic   r_start;

    logic [SWW-1:0] r_scol, r_cs, r_ce;
    logic [SHW-1:0] r_srow, r_rs, r_re, r_drow;
    logic [DCW-1:0] r_dcol;
    logic [3*CH_W-1:0] r_pix;
    logic [MW-1:0]  r_rdata, r_sum;
    logic [NW-1:0]  r_n;

    logic [MW-1:0]  r_mem [MAX_DST_WIDTH];

    logic            r_out_valid;
    logic [CH_W-1:0] r_avg_r, r_avg_g, r_avg_b, r_m_r, r_m_g;
    logic [OCOL_W-1:0] r_ocol;
    logic [OROW_W-1:0] r_orow;
    logic            r_fend;

    logic [SWW-1:0] w_sw;
    logic [SHW-1:0] w_sh, w_th;
    logic [DCW-1:0] w_twl, w_tw;

    logic             w_accept, w_ready, w_emit, w_first, w_load_out;
    logic [DIV_NW-1:0] w_num, w_quot;
    logic [DVW-1:0]   w_den;
    logic             w_div_busy, w_div_done;
    logic [CH_W-1:0]  w_mean;
    logic [MW-1:0]    w_acc;
    logic [SWW-1:0]   w_cw;
    logic [SHW-1:0]   w_rh;

    logic [SWW-1:0] w_nscol;
    logic [SHW-1:0] w_nsrow, w_ndrow;
    logic [DCW-1:0] w_ndcol;

    // effective sizes
    always_comb begin
        if (r_src_w == '0)                       w_sw = SWW'(1);
        else if (32'(r_src_w) > MAX_SRC_WIDTH)   w_sw = SWW'(MAX_SRC_WIDTH);
        else                                     w_sw = SWW'(r_src_w);
        if (r_src_h == '0)                       w_sh = SHW'(1);
        else if (32'(r_src_h) > MAX_SRC_HEIGHT)  w_sh = SHW'(MAX_SRC_HEIGHT);
        else                                     w_sh = SHW'(r_src_h);
        if (32'(w_sw) < MAX_DST_WIDTH)           w_twl = DCW'(w_sw);
        else                                     w_twl = DCW'(MAX_DST_WIDTH);
        if (r_dst_w == '0)                       w_tw = DCW'(1);
        else if (32'(r_dst_w) > 32'(w_twl))      w_tw = w_twl;
        else                                     w_tw = DCW'(r_dst_w);
        if (r_dst_h == '0)                       w_th = SHW'(1);
        else if (32'(r_dst_h) > 32'(w_sh))       w_th = w_sh;
        else                                     w_th = SHW'(r_dst_h);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= 13'd640;
            r_src_h <= 13'd480;
            r_dst_w <= 11'd80;
            r_dst_h <= 13'd24;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SRC_W: r_src_w <= i_cfg_wdata;
                REG_SRC_H: r_src_h <= i_cfg_wdata;
                REG_DST_W: r_dst_w <= i_cfg_wdata[10:0];
                REG_DST_H: r_dst_h <= i_cfg_wdata;
                default:   ;
            endcase
        end
    end

    // divider operands per step
    always_comb begin
        w_num = '0;
        w_den = '0;
        case (r_op)
            OP_CS: begin
                w_num = DIV_NW'({(DCW+SWW+1)'(r_dcol) * (DCW+SWW+1)'(w_sw), 1'b0}) +
                        DIV_NW'(w_tw);
                w_den = DVW'({w_tw, 1'b0});
            end
            OP_CE: begin
                w_num = DIV_NW'({(DCW+SWW+1)'(r_dcol + 1'b1) * (DCW+SWW+1)'(w_sw), 1'b0}) +
                        DIV_NW'(w_tw);
                w_den = DVW'({w_tw, 1'b0});
            end
            OP_RS: begin
                w_num = DIV_NW'({(2*SHW+1)'(r_drow) * (2*SHW+1)'(w_sh), 1'b0}) +
                        DIV_NW'(w_th);
                w_den = DVW'({w_th, 1'b0});
            end
            OP_RE: begin
                w_num = DIV_NW'({(2*SHW+1)'(r_drow + 1'b1) * (2*SHW+1)'(w_sh), 1'b0}) +
                        DIV_NW'(w_th);
                w_den = DVW'({w_th, 1'b0});
            end
            OP_MR: begin
                w_num = {r_sum[SUM_W-1:0], 1'b0} + DIV_NW'(r_n);
                w_den = {r_n, 1'b0};
            end
            OP_MG: begin
                w_num = {r_sum[2*SUM_W-1:SUM_W], 1'b0} + DIV_NW'(r_n);
                w_den = {r_n, 1'b0};
            end
            default: begin
                w_num = {r_sum[3*SUM_W-1:2*SUM_W], 1'b0} + DIV_NW'(r_n);
                w_den = {r_n, 1'b0};
            end
        endcase
    end

    bads_div #(.N_W(DIV_NW), .D_W(DVW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_mean = (w_quot > DIV_NW'(255)) ? 8'hFF : w_quot[CH_W-1:0];

    // region bookkeeping
    always_comb begin
        w_first = (r_scol <= r_cs) && (r_srow <= r_rs);
        w_emit  = (32'(r_scol) + 1 >= 32'(r_ce)) && (32'(r_srow) + 1 >= 32'(r_re));
        w_cw    = (r_ce > r_cs) ? SWW'(r_ce - r_cs) : SWW'(1);
        w_rh    = (r_re > r_rs) ? SHW'(r_re - r_rs) : SHW'(1);
        for (int c = 0; c < 3; c++) begin
            if (w_first)
                w_acc[c*SUM_W +: SUM_W] = SUM_W'(r_pix[c*CH_W +: CH_W]);
            else
                w_acc[c*SUM_W +: SUM_W] = r_rdata[c*SUM_W +: SUM_W] +
                                          SUM_W'(r_pix[c*CH_W +: CH_W]);
        end
    end

    // counter advance after a pixel
    always_comb begin
        w_ndcol = r_dcol;
        w_ndrow = r_drow;
        w_nsrow = r_srow;
        w_nscol = r_scol + 1'b1;
        if (32'(r_scol) + 1 >= 32'(r_ce)) w_ndcol = r_dcol + 1'b1;
        if (w_nscol >= w_sw) begin
            w_nscol = '0;
            w_ndcol = '0;
            if (32'(r_srow) + 1 >= 32'(r_re)) w_ndrow = r_drow + 1'b1;
            w_nsrow = r_srow + 1'b1;
            if (w_nsrow >= w_sh) begin
                w_nsrow = '0;
                w_ndrow = '0;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_pix.valid) n_state = S_DIV;
            S_DIV: begin
                if (w_div_done && r_op == OP_RE) n_state = S_READ;
                else if (w_div_done && r_op == OP_MB) n_state = S_EMIT;
            end
            S_READ: n_state = S_ACC;
            S_ACC:  n_state = w_emit ? S_DIV : S_IDLE;
            S_EMIT: if (!r_out_valid || o_avg.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        w_ready    = (r_state == S_IDLE);
        w_load_out = (r_state == S_EMIT) && (!r_out_valid || o_avg.ready);
    end

    assign w_accept = i_pix.valid && w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_CS;
            r_start     <= 1'b0;
            r_scol      <= '0;
            r_srow      <= '0;
            r_dcol      <= '0;
            r_drow      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= 1'b0;
            if (w_load_out)       r_out_valid <= 1'b1;
            else if (o_avg.ready) r_out_valid <= 1'b0;
            if (w_accept) begin
                if (i_pix.frame_start || r_scol >= w_sw || r_srow >= w_sh ||
                    r_dcol >= w_tw || r_drow >= w_th) begin
                    r_scol <= '0;
                    r_srow <= '0;
                    r_dcol <= '0;
                    r_drow <= '0;
                end
                r_op    <= OP_CS;
                r_start <= 1'b1;
            end
            if (r_state == S_DIV && w_div_done) begin
                case (r_op)
                    OP_CS: begin r_op <= OP_CE; r_start <= 1'b1; end
                    OP_CE: begin r_op <= OP_RS; r_start <= 1'b1; end
                    OP_RS: begin r_op <= OP_RE; r_start <= 1'b1; end
                    OP_MR: begin r_op <= OP_MG; r_start <= 1'b1; end
                    OP_MG: begin r_op <= OP_MB; r_start <= 1'b1; end
                    default: ;
                endcase
            end
            if (r_state == S_ACC) begin
                if (w_emit) begin
                    r_op    <= OP_MR;
                    r_start <= 1'b1;
                end else begin
                    r_scol <= w_nscol;
                    r_srow <= w_nsrow;
                    r_dcol <= w_ndcol;
                    r_drow <= w_ndrow;
                end
            end
            if (w_load_out) begin
                r_scol <= w_nscol;
                r_srow <= w_nsrow;
                r_dcol <= w_ndcol;
                r_drow <= w_ndrow;
            end
        end
    end

    // payload and line store
    always_ff @(posedge i_clk) begin
        if (w_accept)
            r_pix <= {i_pix.pixel_blue, i_pix.pixel_green, i_pix.pixel_red};
        if (r_state == S_DIV && w_div_done) begin
            case (r_op)
                OP_CS: r_cs <= SWW'(w_quot);
                OP_CE: r_ce <= SWW'(w_quot);
                OP_RS: r_rs <= SHW'(w_quot);
                OP_RE: r_re <= SHW'(w_quot);
                OP_MR: r_m_r <= w_mean;
                OP_MG: r_m_g <= w_mean;
                default: ;
            endcase
        end
        if (r_state == S_READ)
            r_rdata <= r_mem[r_dcol[AW-1:0]];
        if (r_state == S_ACC) begin
            r_mem[r_dcol[AW-1:0]] <= w_acc;
            r_sum <= w_acc;
            r_n   <= NW'(w_cw) * NW'(w_rh);
        end
        if (r_state == S_DIV && w_div_done && r_op == OP_MB)
            r_avg_b <= w_mean;
        if (w_load_out) begin
            r_avg_r <= r_m_r;
            r_avg_g <= r_m_g;
            r_ocol  <= OCOL_W'(r_dcol);
            r_orow  <= OROW_W'(r_drow);
            r_fend  <= (w_nscol == '0) && (w_nsrow == '0) &&
                       (32'(r_scol) + 1 == 32'(w_sw)) && (32'(r_srow) + 1 == 32'(w_sh));
        end
    end

    // blue mean lands in r_avg_b ahead of the load; copy it at the load
    logic [CH_W-1:0] r_out_b;
    always_ff @(posedge i_clk) begin
        if (w_load_out) r_out_b <= r_avg_b;
    end

    assign i_pix.ready        = w_ready;
    assign o_avg.valid        = r_out_valid;
    assign o_avg.avg_red      = r_avg_r;
    assign o_avg.avg_green    = r_avg_g;
    assign o_avg.avg_blue     = r_out_b;
    assign o_avg.out_column   = r_ocol;
    assign o_avg.out_row      = r_orow;
    assign o_avg.frame_end    = r_fend;

    `BADS_NEVER(a_start_busy, r_start && w_div_busy, "divider started while busy")
    `BADS_ASSERT(a_done_in_div, w_div_done |-> r_state == S_DIV, "divider result outside a divide step")
    `BADS_ASSERT(a_emit_loads, (r_state == S_EMIT && !r_out_valid) |=> r_out_valid, "free output register not loaded")
    `BADS_NEVER(a_accept_busy, w_accept && w_div_busy, "pixel taken while divider runs")
endmodule
